@@ rtl/rti_pkg.sv @@
package rti_pkg;

    localparam int FIELD_W  = 60;
    localparam int DIST_W   = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int QBITS    = 32;
    localparam int FRAC_T   = 16;

    localparam logic [APB_DW-1:0] DET_THRESHOLD_RST = 32'd1;

    // register index, taken from paddr[APB_AW-1]
    localparam logic REG_DET_THRESHOLD = 1'b0;

    typedef struct packed {
        logic valid;
        logic culled;
    } t_geom_ctl;

    typedef struct packed {
        logic valid;
        logic hit;
        logic sat;
    } t_div_ctl;

endpackage

@@ rtl/rti_ray_if.sv @@
interface rti_ray_if;
    logic                         valid;
    logic                         ready;
    logic [rti_pkg::FIELD_W-1:0]  ray_origin;
    logic [rti_pkg::FIELD_W-1:0]  ray_direction;
    logic [rti_pkg::FIELD_W-1:0]  vertex_a;
    logic [rti_pkg::FIELD_W-1:0]  vertex_b;
    logic [rti_pkg::FIELD_W-1:0]  vertex_c;
    logic [rti_pkg::FIELD_W-1:0]  normal_a;
    logic [rti_pkg::FIELD_W-1:0]  normal_b;
    logic [rti_pkg::FIELD_W-1:0]  normal_c;

    modport source (output valid, ray_origin, ray_direction, vertex_a, vertex_b, vertex_c,
                    normal_a, normal_b, normal_c, input ready);
    modport sink   (input valid, ray_origin, ray_direction, vertex_a, vertex_b, vertex_c,
                    normal_a, normal_b, normal_c, output ready);
endinterface

@@ rtl/rti_res_if.sv @@
interface rti_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [rti_pkg::DIST_W-1:0]  distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

@@ rtl/ray_triangle_intersect.sv @@
// Ray/triangle hit test, one ray and one triangle per word.
// Input channel i_ray carries origin, direction, three vertices and three
// vertex normals, each three signed fixed-point components packed in 60 bits.
// Output channel o_res returns hit and distance t (unsigned Q16.16,
// saturated, 0 on a miss), one result word per input word, in order.
// det_threshold sits at APB address 0; write it while no words are in flight.
// The pipeline has three geometry stages (differences, cross products,
// dot products), sign fix-up, hit classification and 32 restoring-division
// stages producing one quotient bit each. Throughput is one word per cycle unless o_res stalls.
// The whole pipeline advances on one enable: when o_res holds a word that is
// not taken, every stage holds, and i_ray.ready drops only while the last
// stage is full and stalled. Reset empties all stages and sets det_threshold
// to 1; nothing is lost or repeated across a stall.
module ray_triangle_intersect #(
    parameter int COORD_BITS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rti_ray_if.sink                     i_ray,
    rti_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rti_pkg::APB_AW-1:0]  paddr,
    input  logic [rti_pkg::APB_DW-1:0]  pwdata,
    output logic [rti_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rti_pkg::*;

    localparam int PW = 3 * COORD_BITS + 6;
    localparam int RW = PW + QBITS;

    logic              ce;
    logic [APB_DW-1:0] r_thr;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_DET_THRESHOLD) ? r_thr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= DET_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_AW-1] == REG_DET_THRESHOLD) begin
            r_thr <= pwdata;
        end
    end

    t_div_ctl          dctl [QBITS+1];
    logic [PW-1:0]     ddet [QBITS+1];
    logic [RW-1:0]     drem [QBITS+1];
    logic [QBITS-1:0]  dq   [QBITS+1];

    // hold everything while the last word waits
    assign ce          = !dctl[QBITS].valid || o_res.ready;
    assign i_ray.ready = ce;

    t_geom_ctl            gctl;
    logic signed [PW-1:0] g_det, g_tn, g_an, g_bn;

    rti_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_ray.valid),
        .i_org   (i_ray.ray_origin),
        .i_dir   (i_ray.ray_direction),
        .i_va    (i_ray.vertex_a),
        .i_vb    (i_ray.vertex_b),
        .i_vc    (i_ray.vertex_c),
        .i_na    (i_ray.normal_a),
        .i_nb    (i_ray.normal_b),
        .i_nc    (i_ray.normal_c),
        .o_ctl   (gctl),
        .o_det   (g_det),
        .o_tn    (g_tn),
        .o_an    (g_an),
        .o_bn    (g_bn)
    );

    // stage D: make the determinant non-negative
    t_geom_ctl            r_dctl;
    logic signed [PW-1:0] r_det, r_tn, r_an, r_bn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dctl <= '0;
        end else if (ce) begin
            r_dctl <= gctl;
        end
        if (ce) begin
            r_det <= g_det[PW-1] ? -g_det : g_det;
            r_tn  <= g_det[PW-1] ? -g_tn  : g_tn;
            r_an  <= g_det[PW-1] ? -g_an  : g_an;
            r_bn  <= g_det[PW-1] ? -g_bn  : g_bn;
        end
    end

    // stage E: classify
    logic n_hit, n_sat;

    always_comb begin
        n_hit = !r_dctl.culled
                && r_det != '0
                && $unsigned(r_det) >= PW'(r_thr)
                && !r_tn[PW-1] && r_tn != '0
                && !r_an[PW-1] && !r_bn[PW-1]
                && ($unsigned(r_an) + $unsigned(r_bn)) <= $unsigned(r_det);
        n_sat = (PW+FRAC_T)'($unsigned(r_tn)) >= {$unsigned(r_det), {FRAC_T{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dctl[0] <= '0;
        end else if (ce) begin
            dctl[0] <= '{valid: r_dctl.valid, hit: n_hit, sat: n_sat};
        end
        if (ce) begin
            ddet[0] <= $unsigned(r_det);
            drem[0] <= RW'($unsigned(r_tn)) << FRAC_T;
            dq[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        rti_div_step #(.COORD_BITS(COORD_BITS), .STEP(QBITS - 1 - j)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_ctl   (dctl[j]),
            .i_det   (ddet[j]),
            .i_rem   (drem[j]),
            .i_q     (dq[j]),
            .o_ctl   (dctl[j+1]),
            .o_det   (ddet[j+1]),
            .o_rem   (drem[j+1]),
            .o_q     (dq[j+1])
        );
    end

    assign o_res.valid    = dctl[QBITS].valid;
    assign o_res.hit      = dctl[QBITS].hit;
    assign o_res.distance = !dctl[QBITS].hit ? '0
                          : dctl[QBITS].sat  ? '1 : dq[QBITS];

endmodule

@@ rtl/rti_geom.sv @@
module rti_geom #(
    parameter int COORD_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ce,
    input  logic                              i_valid,
    input  logic [rti_pkg::FIELD_W-1:0]       i_org,
    input  logic [rti_pkg::FIELD_W-1:0]       i_dir,
    input  logic [rti_pkg::FIELD_W-1:0]       i_va,
    input  logic [rti_pkg::FIELD_W-1:0]       i_vb,
    input  logic [rti_pkg::FIELD_W-1:0]       i_vc,
    input  logic [rti_pkg::FIELD_W-1:0]       i_na,
    input  logic [rti_pkg::FIELD_W-1:0]       i_nb,
    input  logic [rti_pkg::FIELD_W-1:0]       i_nc,
    output rti_pkg::t_geom_ctl                o_ctl,
    output logic signed [3*COORD_BITS+5:0]    o_det,
    output logic signed [3*COORD_BITS+5:0]    o_tn,
    output logic signed [3*COORD_BITS+5:0]    o_an,
    output logic signed [3*COORD_BITS+5:0]    o_bn
);
    import rti_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int NW = C + 2;
    localparam int XW = 2 * C + 3;
    localparam int CW = 2 * C + 4;
    localparam int PW = 3 * C + 6;

    function automatic logic signed [C-1:0] comp(input logic [FIELD_W-1:0] f, input int k);
        logic [3*C+FIELD_W-1:0] t;
        t = {{(3*C){1'b0}}, f};
        return t[k*C +: C];
    endfunction

    // stage A: differences and normal sum
    logic signed [DW-1:0] n_u [3], n_v [3], n_k [3], n_nd [3];
    logic signed [DW-1:0] r_u [3], r_v [3], r_k [3], r_nd [3];
    logic signed [C-1:0]  n_d [3], r_d [3];
    logic signed [NW-1:0] n_ns [3], r_ns [3];
    logic                 r_va;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u[i]  = DW'(comp(i_vb, i)) - DW'(comp(i_va, i));
            n_v[i]  = DW'(comp(i_vc, i)) - DW'(comp(i_va, i));
            n_k[i]  = DW'(comp(i_org, i)) - DW'(comp(i_va, i));
            n_d[i]  = comp(i_dir, i);
            n_nd[i] = -DW'(comp(i_dir, i));
            n_ns[i] = NW'(comp(i_na, i)) + NW'(comp(i_nb, i)) + NW'(comp(i_nc, i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_ce) begin
            r_va <= i_valid;
        end
        if (i_ce) begin
            r_u <= n_u; r_v <= n_v; r_k <= n_k; r_nd <= n_nd;
            r_d <= n_d; r_ns <= n_ns;
        end
    end

    // stage B: cross products and cull dot
    logic signed [XW-1:0] n_x1 [3], n_x2 [3], n_x3 [3];
    logic signed [XW-1:0] r_x1 [3], r_x2 [3], r_x3 [3];
    logic signed [DW-1:0] r_kb [3], r_ndb [3];
    logic signed [CW-1:0] n_cull;
    logic                 r_vb, r_cullb;

    function automatic logic signed [XW-1:0] xterm(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b,
                                                  input logic signed [DW-1:0] c,
                                                  input logic signed [DW-1:0] d);
        return XW'(a) * XW'(b) - XW'(c) * XW'(d);
    endfunction

    always_comb begin
        n_x1[0] = xterm(r_u[1], r_v[2], r_u[2], r_v[1]);
        n_x1[1] = xterm(r_u[2], r_v[0], r_u[0], r_v[2]);
        n_x1[2] = xterm(r_u[0], r_v[1], r_u[1], r_v[0]);
        n_x2[0] = xterm(r_k[1], r_v[2], r_k[2], r_v[1]);
        n_x2[1] = xterm(r_k[2], r_v[0], r_k[0], r_v[2]);
        n_x2[2] = xterm(r_k[0], r_v[1], r_k[1], r_v[0]);
        n_x3[0] = xterm(r_u[1], r_k[2], r_u[2], r_k[1]);
        n_x3[1] = xterm(r_u[2], r_k[0], r_u[0], r_k[2]);
        n_x3[2] = xterm(r_u[0], r_k[1], r_u[1], r_k[0]);
        n_cull  = '0;
        for (int i = 0; i < 3; i++) begin
            n_cull = n_cull + CW'(r_d[i]) * CW'(r_ns[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_ce) begin
            r_vb <= r_va;
        end
        if (i_ce) begin
            r_x1 <= n_x1; r_x2 <= n_x2; r_x3 <= n_x3;
            r_kb <= r_k; r_ndb <= r_nd;
            // facing along the normal sum (or a zero dot product): drop
            r_cullb <= !n_cull[CW-1];
        end
    end

    // stage C: dot products
    function automatic logic signed [PW-1:0] dot(input logic signed [DW-1:0] a [3],
                                                input logic signed [XW-1:0] b [3]);
        logic signed [PW-1:0] s;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            s = s + PW'(a[i]) * PW'(b[i]);
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.valid <= 1'b0;
        end else if (i_ce) begin
            o_ctl.valid <= r_vb;
        end
        if (i_ce) begin
            o_ctl.culled <= r_cullb;
            o_det <= dot(r_ndb, r_x1);
            o_tn  <= dot(r_kb, r_x1);
            o_an  <= dot(r_ndb, r_x2);
            o_bn  <= dot(r_ndb, r_x3);
        end
    end

endmodule

@@ rtl/rti_div_step.sv @@
module rti_div_step #(
    parameter int COORD_BITS = 20,
    parameter int STEP       = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ce,
    input  rti_pkg::t_div_ctl                   i_ctl,
    input  logic [3*COORD_BITS+5:0]             i_det,
    input  logic [3*COORD_BITS+5+rti_pkg::QBITS:0] i_rem,
    input  logic [rti_pkg::QBITS-1:0]           i_q,
    output rti_pkg::t_div_ctl                   o_ctl,
    output logic [3*COORD_BITS+5:0]             o_det,
    output logic [3*COORD_BITS+5+rti_pkg::QBITS:0] o_rem,
    output logic [rti_pkg::QBITS-1:0]           o_q
);
    import rti_pkg::*;

    localparam int PW = 3 * COORD_BITS + 6;
    localparam int RW = PW + QBITS;

    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(i_det) << STEP;
    assign ge  = (i_rem >= dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_ce) begin
            o_ctl <= i_ctl;
        end
        if (i_ce) begin
            o_det <= i_det;
            o_rem <= ge ? i_rem - dsh : i_rem;
            o_q   <= i_q | (QBITS'(ge) << STEP);
        end
    end

endmodule

@@ rtl/rti_checker.sv @@
module rti_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_hit,
    input logic [rti_pkg::DIST_W-1:0]  i_res_distance,
    input logic                        i_psel,
    input logic                        i_penable,
    input logic                        i_pwrite,
    input logic [rti_pkg::APB_AW-1:0]  i_paddr,
    input logic [rti_pkg::APB_DW-1:0]  i_pwdata,
    input logic [rti_pkg::APB_DW-1:0]  i_prdata,
    input logic                        i_pready
);
    import rti_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_hit)
                                        && $stable(i_res_distance))
        else $error("result word changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_hit |-> i_res_distance == '0)
        else $error("miss with nonzero distance");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_pready
        && i_paddr[APB_AW-1] == REG_DET_THRESHOLD
        |=> i_paddr[APB_AW-1] != REG_DET_THRESHOLD || i_prdata == $past(i_pwdata))
        else $error("threshold readback mismatch");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_hit      (o_res.hit),
    .i_res_distance (o_res.distance),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata),
    .i_pready       (pready)
);
